>>> rtl/core/twst_pkg.sv
// Shared constants, types and helpers of the time window sum threshold block.
`default_nettype none
package twst_pkg;

    localparam int DEPTH     = 64;
    localparam int PTR_W     = $clog2(DEPTH);
    localparam int OCC_W     = $clog2(DEPTH + 1);
    localparam int DAY_W     = 16;
    localparam int CLK_W     = 16;
    localparam int ENT_W     = DAY_W + CLK_W;
    localparam int SUM_W     = 22;
    localparam int ACC_RAW_W = CLK_W + $clog2(DEPTH + 1);
    localparam int ACC_W     = (ACC_RAW_W > SUM_W) ? ACC_RAW_W : SUM_W + 1;
    localparam int CFG_IDX_W = 2;

    localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

    localparam logic [CFG_IDX_W-1:0] REG_MIN_CLICKS  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_DAYS = 2'd1;

    typedef struct packed {
        logic load;
        logic evict;
        logic insert;
    } t_cmd;

    typedef struct packed {
        logic evict_ok;
        logic out_free;
    } t_status;

    function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] q;
        q = (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
        return q;
    endfunction

endpackage
`default_nettype wire

>>> rtl/core/time_window_sum_threshold.sv
// Top level of the sliding time window sum threshold block.
//
// Input stream (s_axis): one item per record of the current key. tdata holds
// day in [15:0] and clicks in [31:16]; tuser[0] is first_of_key, which clears
// the window, the sum and the found flag before the record is taken.
// Output stream (m_axis): one item per input item, in order. tdata holds the
// window sum in [21:0] (saturating); tuser is {overflow, key_found, meets}.
// Config channel: i_cfg_index 0 writes min_clicks, 1 writes window_days
// (0 acts as 1); other indexes are ignored. Always ready; write only when idle.
// Timing: s_axis_tready is high only while the sequencer is idle. An item is
// loaded, then entries are evicted from the window one at a time, each eviction
// being one read of the entry memory at the head pointer, then it is inserted;
// the next item is taken only after that insert. The result appears in the
// output register the cycle after the insert.
// Reset (synchronous, active low) empties the window and the output register
// and loads min_clicks = 1, window_days = 1; the memory is not cleared.
// Stall: a result waiting in the output register does not stop the next item
// from being taken and its evictions from running; its insert waits there.
`default_nettype none
module time_window_sum_threshold (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [31:0] s_axis_tdata,   // [15:0] day, [31:16] clicks
    input  wire  [0:0]  s_axis_tuser,   // [0] first_of_key
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [21:0] window_sum, [23:22] zero
    output logic [2:0]  m_axis_tuser,   // [0] meets_threshold, [1] key_found, [2] overflow
    input  wire         i_cfg_valid,
    output logic        o_cfg_ready,
    input  wire  [twst_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire  [twst_pkg::SUM_W-1:0]     i_cfg_data
);

    twst_pkg::t_cmd    cmd;
    twst_pkg::t_status status;

    logic [twst_pkg::SUM_W-1:0] r_min_clicks;
    logic [twst_pkg::DAY_W-1:0] r_window_days;
    logic [twst_pkg::SUM_W-1:0] out_sum;
    logic                       out_meets, out_found, out_over;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_clicks  <= twst_pkg::SUM_W'(1);
            r_window_days <= twst_pkg::DAY_W'(1);
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                twst_pkg::REG_MIN_CLICKS:  r_min_clicks  <= i_cfg_data;
                twst_pkg::REG_WINDOW_DAYS: r_window_days <= i_cfg_data[twst_pkg::DAY_W-1:0];
                default: ;
            endcase
        end
    end

    twst_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    twst_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_status      (status),
        .i_day         (s_axis_tdata[15:0]),
        .i_clicks      (s_axis_tdata[31:16]),
        .i_first       (s_axis_tuser[0]),
        .i_min_clicks  (r_min_clicks),
        .i_window_days (r_window_days),
        .i_out_ready   (m_axis_tready),
        .o_out_valid   (m_axis_tvalid),
        .o_window_sum  (out_sum),
        .o_meets       (out_meets),
        .o_found       (out_found),
        .o_over        (out_over)
    );

    assign m_axis_tdata = {2'b00, out_sum};
    assign m_axis_tuser = {out_over, out_found, out_meets};

endmodule
`default_nettype wire

>>> rtl/core/twst_ctrl.sv
// Sequencer: takes an item, runs evictions, then issues the insert.
`default_nettype none
module twst_ctrl (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_in_valid,
    output logic             o_in_ready,
    input  twst_pkg::t_status i_status,
    output twst_pkg::t_cmd   o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_WORK = 2'b10
    } t_state;

    t_state r_state, n_state;

    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_WORK;
                end
            end
            S_WORK: begin
                if (i_status.evict_ok) begin
                    o_cmd.evict = 1'b1;
                end else if (i_status.out_free) begin
                    o_cmd.insert = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule
`default_nettype wire

>>> rtl/core/twst_dp.sv
// Datapath: entry FIFO memory, pointers, running sum and result register.
`default_nettype none
module twst_dp (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  twst_pkg::t_cmd                   i_cmd,
    output twst_pkg::t_status                o_status,
    input  wire [twst_pkg::DAY_W-1:0]        i_day,
    input  wire [twst_pkg::CLK_W-1:0]        i_clicks,
    input  wire                              i_first,
    input  wire [twst_pkg::SUM_W-1:0]        i_min_clicks,
    input  wire [twst_pkg::DAY_W-1:0]        i_window_days,
    input  wire                              i_out_ready,
    output logic                             o_out_valid,
    output logic [twst_pkg::SUM_W-1:0]       o_window_sum,
    output logic                             o_meets,
    output logic                             o_found,
    output logic                             o_over
);

    logic [twst_pkg::ENT_W-1:0] mem [twst_pkg::DEPTH];

    logic [twst_pkg::PTR_W-1:0] r_head, n_head, r_tail, n_tail;
    logic [twst_pkg::OCC_W-1:0] r_occ, n_occ;
    logic [twst_pkg::ACC_W-1:0] r_sum, n_sum;
    logic                       r_found, n_found;
    logic                       r_out_valid;
    logic [twst_pkg::DAY_W-1:0] r_day;
    logic [twst_pkg::CLK_W-1:0] r_clicks;
    logic [twst_pkg::ENT_W-1:0] r_rd;
    logic [twst_pkg::SUM_W-1:0] r_out_sum;
    logic                       r_out_meets, r_out_found, r_out_over;

    logic [twst_pkg::DAY_W-1:0] old_day, span, gap;
    logic [twst_pkg::CLK_W-1:0] old_cnt;
    logic                       full, meets;
    logic [twst_pkg::ACC_W-1:0] ins_sum;

    // head entry from the registered read: day low, count high
    assign old_day = r_rd[twst_pkg::DAY_W-1:0];
    assign old_cnt = r_rd[twst_pkg::ENT_W-1:twst_pkg::DAY_W];
    assign span    = (i_window_days == '0) ? twst_pkg::DAY_W'(1) : i_window_days;
    assign gap     = r_day - old_day;
    assign full    = (r_occ == twst_pkg::OCC_W'(twst_pkg::DEPTH));

    assign o_status.evict_ok = (r_occ != '0) && (r_day >= old_day) && (gap >= span);
    assign o_status.out_free = !r_out_valid || i_out_ready;

    assign ins_sum = r_sum - (full ? twst_pkg::ACC_W'(old_cnt) : '0)
                   + twst_pkg::ACC_W'(r_clicks);
    assign meets   = ins_sum >= twst_pkg::ACC_W'(i_min_clicks);

    always_comb begin
        n_head  = r_head;
        n_tail  = r_tail;
        n_occ   = r_occ;
        n_sum   = r_sum;
        n_found = r_found;
        if (i_cmd.load && i_first) begin
            n_head  = '0;
            n_tail  = '0;
            n_occ   = '0;
            n_sum   = '0;
            n_found = 1'b0;
        end else if (i_cmd.evict) begin
            n_head = twst_pkg::next_slot(r_head);
            n_occ  = r_occ - 1'b1;
            n_sum  = r_sum - twst_pkg::ACC_W'(old_cnt);
        end else if (i_cmd.insert) begin
            // a full FIFO drops its oldest entry, so occupancy stays put
            n_head  = full ? twst_pkg::next_slot(r_head) : r_head;
            n_occ   = full ? r_occ : r_occ + 1'b1;
            n_tail  = twst_pkg::next_slot(r_tail);
            n_sum   = ins_sum;
            n_found = r_found | meets;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head      <= '0;
            r_tail      <= '0;
            r_occ       <= '0;
            r_sum       <= '0;
            r_found     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_occ   <= n_occ;
            r_sum   <= n_sum;
            r_found <= n_found;
            if (i_cmd.insert) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // item latch and result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_day    <= i_day;
            r_clicks <= i_clicks;
        end
        if (i_cmd.insert) begin
            r_out_sum   <= (ins_sum > twst_pkg::ACC_W'(twst_pkg::SUM_MAX))
                         ? twst_pkg::SUM_MAX : ins_sum[twst_pkg::SUM_W-1:0];
            r_out_meets <= meets;
            r_out_found <= r_found | meets;
            r_out_over  <= full;
        end
    end

    // entry memory: write at tail, registered read at the next head
    always_ff @(posedge i_clk) begin
        if (i_cmd.insert) begin
            mem[r_tail] <= {r_clicks, r_day};
        end
        if (i_cmd.insert && (r_tail == n_head)) begin
            r_rd <= {r_clicks, r_day};
        end else begin
            r_rd <= mem[n_head];
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_window_sum = r_out_sum;
    assign o_meets      = r_out_meets;
    assign o_found      = r_out_found;
    assign o_over       = r_out_over;

endmodule
`default_nettype wire

>>> rtl/core/twst_checker.sv
// Port-level checks of the time window sum threshold block, bound to the top.
`default_nettype none
module twst_checker (
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        s_axis_tvalid,
    input wire        s_axis_tready,
    input wire        m_axis_tvalid,
    input wire        m_axis_tready,
    input wire [23:0] m_axis_tdata,
    input wire [2:0]  m_axis_tuser
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
                                            && $stable(m_axis_tuser))
        else $error("stalled result changed");

    // one item at a time: busy right after taking an item
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input ready right after an item");

    // no result can appear the cycle after an item is taken into an empty output
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && !m_axis_tvalid |=> !m_axis_tvalid)
        else $error("result too early");

    // threshold met implies the sticky flag
    a_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !m_axis_tuser[0] || m_axis_tuser[1])
        else $error("meets without key_found");

    a_pad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[23:22] == 2'b00)
        else $error("pad bits set");

endmodule

bind time_window_sum_threshold twst_checker u_twst_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
`default_nettype wire
